// ===== sv/plli_pkg.sv =====
// Package for the per-channel curve interpolator.
// Holds widths, request and register codes, and the structs passed between stages.
// No dependencies.
package plli_pkg;

  localparam int CHANNELS    = 4;
  localparam int POINTS      = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int CH_W       = $clog2(CHANNELS);
  localparam int IDX_W      = $clog2(POINTS);
  localparam int ADDR_W     = CH_W + IDX_W;
  localparam int TABLE_SIZE = CHANNELS * POINTS;
  localparam int IDX_MAX    = POINTS - 2;

  localparam int VAL_W     = 16;
  localparam int OFS_W     = 17;
  localparam int SCL_W     = 24;
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = ((SAMPLE_BITS > OFS_W) ? SAMPLE_BITS : OFS_W) + 1;
  localparam int POS_W     = SUM_W + SCL_W;
  localparam int IPOS_W    = POS_W - FRAC_BITS;
  localparam int FRAC_W    = POS_W + 1;
  localparam int FH_W      = FRAC_W - FRAC_BITS;
  localparam int DIF_W     = VAL_W + 1;
  localparam int PA_W      = DIF_W + FH_W;
  localparam int PB_W      = DIF_W + FRAC_BITS + 1;
  localparam int ACC_W     = PA_W + 2;
  localparam int RES_W     = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCL_W;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 40;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 1'b0,
    CFG_SCALE  = 1'b1
  } cfg_e;

  typedef struct packed {
    req_e                     req;
    logic [CH_W-1:0]          ch;
    logic [IDX_W-1:0]         pt;
    logic signed [VAL_W-1:0]  val;
  } item_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } pos_ctl_t;

  typedef struct packed {
    logic ld;
    logic wr;
  } fetch_ctl_t;

  typedef struct packed {
    logic ld_d;
    logic ld_e;
    logic ld_f;
  } mac_ctl_t;

endpackage

// ===== sv/per_channel_lut_linear_interp.sv =====
// Per-channel tabulated curve with linear interpolation, six register stages.
// Throughput 1 item per cycle while the output is not stalled.
// Each stage holds while its successor is full and stalled; output stall alone backpressures.
// Table writes retire at the segment stage and produce no output transfer.
// Reset clears valid bits and sets offset 0, scale 1.0; the curve memory is not cleared.
module per_channel_lut_linear_interp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [plli_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // channel, point_index, point_value, sample
  input  logic [0:0]                             s_axis_tuser,  // req_type
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [plli_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // out_channel, result
  output logic [0:0]                             m_axis_tuser,  // saturated
  input  logic                                   cfg_we_i,
  input  logic [plli_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [plli_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import plli_pkg::*;

  logic signed [OFS_W-1:0]        offset_q;
  logic signed [SCL_W-1:0]        scale_q;
  item_t                          item_in;
  logic signed [SAMPLE_BITS-1:0]  sample_in;
  item_t                          item_b;
  logic signed [POS_W-1:0]        pos_b;
  logic [CH_W-1:0]                ch_c;
  logic signed [VAL_W-1:0]        f0_c;
  logic signed [VAL_W-1:0]        f1_c;
  logic signed [FRAC_W-1:0]       frac_c;
  logic [CH_W-1:0]                ch_f;
  logic signed [RES_W-1:0]        res_f;
  logic                           sat_f;
  pos_ctl_t                       pos_ctl;
  fetch_ctl_t                     fetch_ctl;
  mac_ctl_t                       mac_ctl;
  logic                           vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q, vld_f_q;
  logic                           rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      scale_q  <= SCL_W'(32'sd65536);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_OFFSET: offset_q <= cfg_data_i[OFS_W-1:0];
        CFG_SCALE:  scale_q  <= cfg_data_i[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_in.req = req_e'(s_axis_tuser[0]);
  assign item_in.ch  = s_axis_tdata[1:0];
  assign item_in.pt  = s_axis_tdata[9:2];
  assign item_in.val = s_axis_tdata[25:10];
  assign sample_in   = s_axis_tdata[41:26];

  assign rdy_f = !vld_f_q || m_axis_tready;
  assign rdy_e = !vld_e_q || rdy_f;
  assign rdy_d = !vld_d_q || rdy_e;
  assign rdy_c = !vld_c_q || rdy_d;
  assign rdy_b = !vld_b_q || rdy_c;
  assign rdy_a = !vld_a_q || rdy_b;

  assign pos_ctl.ld_a  = s_axis_tvalid && rdy_a;
  assign pos_ctl.ld_b  = vld_a_q && rdy_b;
  assign fetch_ctl.ld  = vld_b_q && rdy_c;
  assign fetch_ctl.wr  = vld_b_q && rdy_c && (item_b.req == REQ_WRITE);
  assign mac_ctl.ld_d  = vld_c_q && rdy_d;
  assign mac_ctl.ld_e  = vld_d_q && rdy_e;
  assign mac_ctl.ld_f  = vld_e_q && rdy_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= s_axis_tvalid;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q && (item_b.req == REQ_SAMPLE);
      if (rdy_d) vld_d_q <= vld_c_q;
      if (rdy_e) vld_e_q <= vld_d_q;
      if (rdy_f) vld_f_q <= vld_e_q;
    end
  end

  plli_pos u_pos (
    .clk_i    (clk_i),
    .ctl_i    (pos_ctl),
    .item_i   (item_in),
    .sample_i (sample_in),
    .offset_i (offset_q),
    .scale_i  (scale_q),
    .item_o   (item_b),
    .pos_o    (pos_b)
  );

  plli_fetch u_fetch (
    .clk_i  (clk_i),
    .ctl_i  (fetch_ctl),
    .item_i (item_b),
    .pos_i  (pos_b),
    .ch_o   (ch_c),
    .f0_o   (f0_c),
    .f1_o   (f1_c),
    .frac_o (frac_c)
  );

  plli_mac u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .ch_i     (ch_c),
    .f0_i     (f0_c),
    .f1_i     (f1_c),
    .frac_i   (frac_c),
    .ch_o     (ch_f),
    .result_o (res_f),
    .sat_o    (sat_f)
  );

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = vld_f_q;
  assign m_axis_tdata  = {{(M_TDATA_W-RES_W-CH_W){1'b0}}, res_f, ch_f};
  assign m_axis_tuser  = sat_f;

endmodule

// ===== sv/plli_pos.sv =====
// Position stages: offset add, then scale multiply into a Q.16 table position.
// Depends on plli_pkg.
module plli_pos (
  input  logic                                   clk_i,
  input  plli_pkg::pos_ctl_t                     ctl_i,
  input  plli_pkg::item_t                        item_i,
  input  logic signed [plli_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [plli_pkg::OFS_W-1:0]      offset_i,
  input  logic signed [plli_pkg::SCL_W-1:0]      scale_i,
  output plli_pkg::item_t                        item_o,
  output logic signed [plli_pkg::POS_W-1:0]      pos_o
);
  import plli_pkg::*;

  item_t                    item_a_q;
  item_t                    item_b_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [POS_W-1:0]  pos_d;
  logic signed [POS_W-1:0]  pos_q;

  assign sum_d = SUM_W'(sample_i) + SUM_W'(offset_i);
  assign pos_d = sum_q * scale_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_a) begin
      item_a_q <= item_i;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_b) begin
      item_b_q <= item_a_q;
      pos_q    <= pos_d;
    end
  end

  assign item_o = item_b_q;
  assign pos_o  = pos_q;

endmodule

// ===== sv/plli_fetch.sv =====
// Segment stage: clamp the segment index, split off the fraction and read both
// control points from the curve memory; control-point writes land here too. Depends on plli_pkg.
module plli_fetch (
  input  logic                                   clk_i,
  input  plli_pkg::fetch_ctl_t                   ctl_i,
  input  plli_pkg::item_t                        item_i,
  input  logic signed [plli_pkg::POS_W-1:0]      pos_i,
  output logic [plli_pkg::CH_W-1:0]              ch_o,
  output logic signed [plli_pkg::VAL_W-1:0]      f0_o,
  output logic signed [plli_pkg::VAL_W-1:0]      f1_o,
  output logic signed [plli_pkg::FRAC_W-1:0]     frac_o
);
  import plli_pkg::*;

  localparam logic signed [IPOS_W-1:0] IdxHi     = IPOS_W'(IDX_MAX);
  localparam logic signed [FRAC_W-1:0] HiOffset  = FRAC_W'(IDX_MAX) <<< FRAC_BITS;

  logic [VAL_W-1:0]          mem_q [TABLE_SIZE];
  logic signed [IPOS_W-1:0]  idx_raw;
  logic [IDX_W-1:0]          idx;
  logic signed [FRAC_W-1:0]  frac_d;
  logic [ADDR_W-1:0]         rd_addr0;
  logic [ADDR_W-1:0]         rd_addr1;
  logic [ADDR_W-1:0]         wr_addr;
  logic [CH_W-1:0]           ch_q;
  logic signed [VAL_W-1:0]   f0_q;
  logic signed [VAL_W-1:0]   f1_q;
  logic signed [FRAC_W-1:0]  frac_q;

  assign idx_raw = pos_i[POS_W-1:FRAC_BITS];

  always_comb begin
    idx    = '0;
    frac_d = '0;
    if (idx_raw[IPOS_W-1]) begin
      idx    = '0;
      frac_d = FRAC_W'(pos_i);
    end else if (idx_raw > IdxHi) begin
      idx    = IDX_W'(IDX_MAX);
      frac_d = FRAC_W'(pos_i) - HiOffset;
    end else begin
      idx                       = idx_raw[IDX_W-1:0];
      frac_d[FRAC_BITS-1:0]     = pos_i[FRAC_BITS-1:0];
    end
  end

  assign rd_addr0 = {item_i.ch, idx};
  assign rd_addr1 = {item_i.ch, IDX_W'(idx + 1'b1)};
  assign wr_addr  = {item_i.ch, item_i.pt};

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr] <= item_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld) begin
      f0_q   <= mem_q[rd_addr0];
      f1_q   <= mem_q[rd_addr1];
      ch_q   <= item_i.ch;
      frac_q <= frac_d;
    end
  end

  assign ch_o   = ch_q;
  assign f0_o   = f0_q;
  assign f1_o   = f1_q;
  assign frac_o = frac_q;

endmodule

// ===== sv/plli_mac.sv =====
// Interpolation stages: slope times fraction in two partial products, accumulate with
// truncation toward zero, then saturate into the output register. Depends on plli_pkg.
module plli_mac (
  input  logic                                   clk_i,
  input  plli_pkg::mac_ctl_t                     ctl_i,
  input  logic [plli_pkg::CH_W-1:0]              ch_i,
  input  logic signed [plli_pkg::VAL_W-1:0]      f0_i,
  input  logic signed [plli_pkg::VAL_W-1:0]      f1_i,
  input  logic signed [plli_pkg::FRAC_W-1:0]     frac_i,
  output logic [plli_pkg::CH_W-1:0]              ch_o,
  output logic signed [plli_pkg::RES_W-1:0]      result_o,
  output logic                                   sat_o
);
  import plli_pkg::*;

  localparam logic signed [RES_W-1:0] ResMax = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] ResMin = {1'b1, {(RES_W-1){1'b0}}};

  logic signed [DIF_W-1:0]      dif;
  logic signed [FH_W-1:0]       fh;
  logic signed [FRAC_BITS:0]    fl;
  logic signed [PA_W-1:0]       pa_d;
  logic signed [PB_W-1:0]       pb_d;
  logic signed [PA_W-1:0]       pa_q;
  logic signed [PB_W-1:0]       pb_q;
  logic signed [VAL_W-1:0]      f0_q;
  logic [CH_W-1:0]              ch_d_q;
  logic signed [ACC_W-1:0]      floor_sum;
  logic                         rem_nz;
  logic signed [ACC_W-1:0]      t_d;
  logic signed [ACC_W-1:0]      t_q;
  logic [CH_W-1:0]              ch_e_q;
  logic                         ovf;
  logic signed [RES_W-1:0]      res_d;
  logic signed [RES_W-1:0]      res_q;
  logic                         sat_q;
  logic [CH_W-1:0]              ch_f_q;

  assign dif  = DIF_W'(f1_i) - DIF_W'(f0_i);
  assign fh   = frac_i[FRAC_W-1:FRAC_BITS];
  assign fl   = {1'b0, frac_i[FRAC_BITS-1:0]};
  assign pa_d = dif * fh;
  assign pb_d = dif * fl;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_d) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      f0_q   <= f0_i;
      ch_d_q <= ch_i;
    end
  end

  assign floor_sum = ACC_W'(f0_q) + ACC_W'(pa_q) + ACC_W'(pb_q >>> FRAC_BITS);
  assign rem_nz    = |pb_q[FRAC_BITS-1:0];
  assign t_d       = (floor_sum[ACC_W-1] && rem_nz) ? floor_sum + ACC_W'(1) : floor_sum;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_e) begin
      t_q    <= t_d;
      ch_e_q <= ch_d_q;
    end
  end

  assign ovf   = !((&t_q[ACC_W-1:RES_W-1]) || !(|t_q[ACC_W-1:RES_W-1]));
  assign res_d = ovf ? (t_q[ACC_W-1] ? ResMin : ResMax) : t_q[RES_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_f) begin
      res_q  <= res_d;
      sat_q  <= ovf;
      ch_f_q <= ch_e_q;
    end
  end

  assign ch_o     = ch_f_q;
  assign result_o = res_q;
  assign sat_o    = sat_q;

endmodule

// ===== sv/plli_chk.sv =====
// Port-level checker for the curve interpolator, bound to the top level.
// Depends on plli_pkg and per_channel_lut_linear_interp.
module plli_chk (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tready,
  input  logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic [plli_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  input  logic [0:0]                             m_axis_tuser
);
  import plli_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer dropped or changed while stalled");

  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[CH_W+RES_W-1:CH_W] == 32'h7fff_ffff ||
      m_axis_tdata[CH_W+RES_W-1:CH_W] == 32'h8000_0000)
    else $error("saturated flag with an unclipped result");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:CH_W+RES_W] == '0)
    else $error("output padding bits not zero");

endmodule

bind per_channel_lut_linear_interp plli_chk u_plli_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
